@@ hdl/integer_pixel_replication_upscaler_core_defines.svh @@
// assertion helpers for the upscaler core
`ifndef INTEGER_PIXEL_REPLICATION_UPSCALER_CORE_DEFINES_SVH
`define INTEGER_PIXEL_REPLICATION_UPSCALER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IPU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ipu_pkg.sv @@
package ipu_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_SCALE = 100;
    localparam int IN_WIDTH_W    = 13;
    localparam int SCALE_W       = 7;
    localparam int COLOR_W       = 8;
    localparam int PIXEL_W       = 3 * COLOR_W;
    localparam int REG_INDEX_W   = 1;
    localparam int RES_DEPTH     = 4;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_PAD    = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_IN_WIDTH = 1'b0,
        REG_SCALE    = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_PIXELS,
        ST_PADS
    } fsm_state_t;

    typedef struct packed {
        kind_t kind;
        logic  row_end;
        logic  pass_end;
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               row_end;
        logic               pass_end;
    } result_t;

endpackage

@@ hdl/ipu_ram.sv @@
module ipu_ram
#(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
)
(
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ipu_front.sv @@
module ipu_front
    import ipu_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_SCALE = DEF_MAX_SCALE,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   operation,
    input  logic [COLOR_W-1:0]     red_in,
    input  logic [COLOR_W-1:0]     green_in,
    input  logic [COLOR_W-1:0]     blue_in,
    input  logic                   cfg_we,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [IN_WIDTH_W-1:0]  cfg_data,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    output logic                   ram_we,
    output logic [AW-1:0]          ram_waddr,
    output logic [PIXEL_W-1:0]     ram_wdata,
    output logic                   ram_re,
    output logic [AW-1:0]          ram_raddr
);

    localparam int CW = AW + 1;
    localparam int SW = $clog2(MAX_SCALE + 1);

    logic [IN_WIDTH_W-1:0] in_width_reg;
    logic [SCALE_W-1:0]    scale_reg;

    fsm_state_t state_reg, state_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic [AW-1:0] rcol_reg, rcol_next;
    logic [SW-1:0] hcopy_reg, hcopy_next;
    logic [SW-1:0] vcopy_reg, vcopy_next;
    logic [1:0]    padc_reg, padc_next;

    logic [CW-1:0] eff_w;
    logic [SW-1:0] eff_s;
    logic [3:0]    pad_prod;
    logic [1:0]    pad;
    logic          fill_last, rcol_last, hcopy_last, vcopy_last, padc_last;
    logic          row_end_c;

    // clamp registers into their legal ranges
    always_comb
    begin
        if (in_width_reg == '0)
        begin
            eff_w = CW'(1);
        end
        else if (32'(in_width_reg) > MAX_WIDTH)
        begin
            eff_w = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CW'(in_width_reg);
        end

        if (scale_reg == '0)
        begin
            eff_s = SW'(1);
        end
        else if (32'(scale_reg) > MAX_SCALE)
        begin
            eff_s = SW'(MAX_SCALE);
        end
        else
        begin
            eff_s = SW'(scale_reg);
        end
    end

    // row pad count only needs the low two bits of width and scale
    assign pad_prod = 4'(2'(eff_w)) * 4'(2'(eff_s));
    assign pad      = pad_prod[1:0];

    assign fill_last  = (CW'(fill_reg) + CW'(1)) >= eff_w;
    assign rcol_last  = (CW'(rcol_reg) + CW'(1)) >= eff_w;
    assign hcopy_last = ((SW + 1)'(hcopy_reg) + (SW + 1)'(1)) >= (SW + 1)'(eff_s);
    assign vcopy_last = ((SW + 1)'(vcopy_reg) + (SW + 1)'(1)) >= (SW + 1)'(eff_s);
    assign padc_last  = (3'(padc_reg) + 3'd1) >= 3'(pad);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg <= IN_WIDTH_W'(1);
            scale_reg    <= SCALE_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_WIDTH: in_width_reg <= cfg_data;
                REG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
            rcol_reg  <= '0;
            hcopy_reg <= '0;
            vcopy_reg <= '0;
            padc_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rcol_reg  <= rcol_next;
            hcopy_reg <= hcopy_next;
            vcopy_reg <= vcopy_next;
            padc_reg  <= padc_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rcol_next    = rcol_reg;
        hcopy_next   = hcopy_reg;
        vcopy_next   = vcopy_reg;
        padc_next    = padc_reg;
        row_end_c    = 1'b0;
        cmd.kind     = KIND_NONE;
        cmd.row_end  = 1'b0;
        cmd.pass_end = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        if (in_valid)
        begin
            if (operation == OP_PUSH)
            begin
                if (state_reg != ST_FILL)
                begin
                    cmd.kind = KIND_REJECT;
                end
                else
                begin
                    ram_we = 1'b1;
                    if (fill_last)
                    begin
                        fill_next  = '0;
                        state_next = ST_PIXELS;
                        rcol_next  = '0;
                        hcopy_next = '0;
                        vcopy_next = '0;
                        padc_next  = '0;
                    end
                    else
                    begin
                        fill_next = fill_reg + AW'(1);
                    end
                end
            end
            else
            begin
                case (state_reg)
                    ST_PIXELS:
                    begin
                        cmd.kind = KIND_PIXEL;
                        ram_re   = 1'b1;
                        if (hcopy_last)
                        begin
                            hcopy_next = '0;
                            if (rcol_last)
                            begin
                                rcol_next = '0;
                                if (pad == 2'd0)
                                begin
                                    row_end_c = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_PADS;
                                    padc_next  = '0;
                                end
                            end
                            else
                            begin
                                rcol_next = rcol_reg + AW'(1);
                            end
                        end
                        else
                        begin
                            hcopy_next = hcopy_reg + SW'(1);
                        end
                    end
                    ST_PADS:
                    begin
                        cmd.kind = KIND_PAD;
                        if (padc_last)
                        begin
                            row_end_c = 1'b1;
                        end
                        else
                        begin
                            padc_next = padc_reg + 2'd1;
                        end
                    end
                    default: ;
                endcase

                if (row_end_c)
                begin
                    cmd.row_end = 1'b1;
                    state_next  = ST_PIXELS;
                    padc_next   = '0;
                    rcol_next   = '0;
                    hcopy_next  = '0;
                    if (vcopy_last)
                    begin
                        // last copy of the row: line buffer free for the next row
                        vcopy_next   = '0;
                        cmd.pass_end = 1'b1;
                        state_next   = ST_FILL;
                    end
                    else
                    begin
                        vcopy_next = vcopy_reg + SW'(1);
                    end
                end
            end
        end
    end

    assign cmd_valid = in_valid;
    assign ram_waddr = fill_reg;
    assign ram_wdata = {red_in, green_in, blue_in};
    assign ram_raddr = rcol_reg;

endmodule

@@ hdl/ipu_back.sv @@
module ipu_back
    import ipu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    input  logic [PIXEL_W-1:0] rd_data,
    input  logic               pop,
    output logic               full,
    output logic               empty,
    output result_t            res
);

    localparam int PW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int NW = $clog2(RES_DEPTH + 1);

    logic          stage_valid_reg;
    cmd_t          stage_cmd_reg;
    result_t       fifo_reg [RES_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [NW-1:0] count_reg, count_next;
    result_t       res_in;
    logic          pop_ok;

    // pixel read data arrives in the cycle after the item, alongside the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            stage_cmd_reg <= cmd;
        end
    end

    always_comb
    begin
        res_in.kind     = stage_cmd_reg.kind;
        res_in.row_end  = stage_cmd_reg.row_end;
        res_in.pass_end = stage_cmd_reg.pass_end;
        if (stage_cmd_reg.kind == KIND_PIXEL)
        begin
            res_in.red   = rd_data[3*COLOR_W-1:2*COLOR_W];
            res_in.green = rd_data[2*COLOR_W-1:COLOR_W];
            res_in.blue  = rd_data[COLOR_W-1:0];
        end
        else
        begin
            res_in.red   = '0;
            res_in.green = '0;
            res_in.blue  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            fifo_reg[wptr_reg] <= res_in;
        end
    end

    assign pop_ok = pop && (count_reg != '0);

    always_comb
    begin
        wptr_next  = stage_valid_reg ? PW'((32'(wptr_reg) + 1) % RES_DEPTH) : wptr_reg;
        rptr_next  = pop_ok ? PW'((32'(rptr_reg) + 1) % RES_DEPTH) : rptr_reg;
        count_next = count_reg + NW'(stage_valid_reg) - NW'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // the item in the stage already holds a queue slot
    assign full  = (32'(count_reg) + 32'(stage_valid_reg)) >= RES_DEPTH;
    assign empty = (count_reg == '0);
    assign res   = fifo_reg[rptr_reg];

endmodule

@@ hdl/integer_pixel_replication_upscaler_core.sv @@
// path: an accepted item is registered in the stage, then written into the result queue
// throughput: one item per cycle while not full; a tick that emits a pixel uses the line
//   buffer read port, a push its write port; a 4-entry result queue absorbs output stalls
// reset: rst_n is asynchronous, active low; clears all counters, the queue, width and
//   scale to 1; the line buffer is not cleared and needs no clearing pass
`include "integer_pixel_replication_upscaler_core_defines.svh"

module integer_pixel_replication_upscaler_core
    import ipu_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_SCALE = DEF_MAX_SCALE
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   operation,
    input  logic [COLOR_W-1:0]     red_in,
    input  logic [COLOR_W-1:0]     green_in,
    input  logic [COLOR_W-1:0]     blue_in,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             kind,
    output logic [COLOR_W-1:0]     red_out,
    output logic [COLOR_W-1:0]     green_out,
    output logic [COLOR_W-1:0]     blue_out,
    output logic                   row_end,
    output logic                   pass_end,
    input  logic                   cfg_we,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [IN_WIDTH_W-1:0]  cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic               accept;
    logic               cmd_valid;
    cmd_t               cmd;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [PIXEL_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [PIXEL_W-1:0] ram_rdata;
    result_t            res;
    logic               pass_out;
    logic               non_pixel_out;
    logic               color_zero;
    logic               reject_cmd;

    assign accept = push && !full;

    ipu_front
    #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    )
    u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .operation (operation),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    ipu_ram
    #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    )
    u_line_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ipu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .rd_data   (ram_rdata),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .res       (res)
    );

    assign kind      = res.kind;
    assign red_out   = res.red;
    assign green_out = res.green;
    assign blue_out  = res.blue;
    assign row_end   = res.row_end;
    assign pass_end  = res.pass_end;

    assign pass_out      = !empty && pass_end;
    assign non_pixel_out = !empty && (kind != KIND_PIXEL);
    assign color_zero    = (red_out == '0) && (green_out == '0) && (blue_out == '0);
    assign reject_cmd    = cmd_valid && (cmd.kind == KIND_REJECT);

    `IPU_ASSERT_NOW(a_accept_reaches_queue, clk, rst_n, accept, ##2 !empty, "item lost")
    `IPU_ASSERT_NOW(a_pass_end_is_row_end, clk, rst_n, pass_out, row_end, "pass end alone")
    `IPU_ASSERT_NOW(a_color_only_on_pixel, clk, rst_n, non_pixel_out, color_zero, "stray color")
    `IPU_ASSERT_NOW(a_reject_no_write, clk, rst_n, reject_cmd, !ram_we, "write on a reject")

endmodule
